FILE: src/caeg_pkg.sv
// Package for the cosine angle energy/gradient block.
// Holds the item types, the sequencer state type, constants and saturation helper.
// No dependencies.
package caeg_pkg;

  localparam int MAX_POWER_DEF = 6;
  localparam int NUM_TYPES_DEF = 64;

  localparam int DIV_NW  = 64;
  localparam int DIV_DW  = 32;
  localparam int SQRT_NW = 64;
  localparam int SQRT_RW = 32;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  localparam logic signed [31:0] ONE30     = 32'sh4000_0000;
  localparam logic signed [31:0] NEG_ONE30 = -32'sh4000_0000;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_8000_0000_0000;

  typedef struct packed {
    logic               mode;
    logic [5:0]         term_type;
    logic [2:0]         power_index;
    logic signed [31:0] coefficient;
    logic signed [31:0] disp_ij_x;
    logic signed [31:0] disp_ij_y;
    logic signed [31:0] disp_ij_z;
    logic signed [31:0] disp_kj_x;
    logic signed [31:0] disp_kj_y;
    logic signed [31:0] disp_kj_z;
    logic               last_term;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] term_energy;
    logic signed [47:0] energy_sum;
    logic signed [47:0] grad_first_x;
    logic signed [47:0] grad_first_y;
    logic signed [47:0] grad_first_z;
    logic signed [47:0] grad_center_x;
    logic signed [47:0] grad_center_y;
    logic signed [47:0] grad_center_z;
    logic signed [47:0] grad_third_x;
    logic signed [47:0] grad_third_y;
    logic signed [47:0] grad_third_z;
    logic               degenerate;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_SQ_MUL, ST_SQ_ACC, ST_SQ_CHK,
    ST_SQRT_GO, ST_SQRT_WAIT,
    ST_NORM_GO, ST_NORM_WAIT,
    ST_DOT_MUL, ST_DOT_ACC, ST_COS,
    ST_P_RD, ST_P_LAT, ST_P_M1, ST_P_M2, ST_P_M3, ST_P_M4, ST_P_M5,
    ST_G_M1, ST_G_M2, ST_G_DIV, ST_G_WAIT,
    ST_FIN
  } caeg_state_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] c;
    begin
      c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return c[47:0];
    end
  endfunction

endpackage

FILE: src/caeg_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
// Depends on caeg_pkg for operand widths.
module caeg_div
  import caeg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIV_NW-1:0] quotient
);
  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW-1:0] rem;
  logic [CW-1:0]     cnt;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;

  assign rem_sh   = {rem, num[DIV_NW-1]};
  assign diff     = rem_sh - {1'b0, den};
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (!diff[DIV_DW]) begin
        rem <= diff[DIV_DW-1:0];
        num <= {num[DIV_NW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_DW-1:0];
        num <= {num[DIV_NW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: src/caeg_sqrt.sv
// Floor integer square root, two radicand bits per cycle.
// Depends on caeg_pkg for operand widths.
module caeg_sqrt
  import caeg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SQRT_NW-1:0] radicand,
  output logic               busy,
  output logic               done,
  output logic [SQRT_RW-1:0] root
);
  localparam int CW = $clog2(SQRT_RW);
  localparam int RMW = SQRT_RW + 2;

  logic [SQRT_NW-1:0] num;
  logic [RMW-1:0]     rem;
  logic [CW-1:0]      cnt;
  logic [RMW+1:0]     rem_sh;
  logic [RMW+1:0]     trial;
  logic               ge;

  assign rem_sh = {rem, num[SQRT_NW-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(SQRT_RW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      num  <= {num[SQRT_NW-3:0], 2'b00};
      rem  <= ge ? RMW'(rem_sh - trial) : RMW'(rem_sh);
      root <= {root[SQRT_RW-2:0], ge};
    end
  end

endmodule

FILE: src/cosine_angle_energy_gradient_top.sv
// Top level of the cosine angle energy/gradient block: sequencer, shared multiplier,
// coefficient memory, energy accumulator and output register.
// Depends on caeg_pkg, caeg_div and caeg_sqrt.
//
// After reset the coefficient memory is cleared, one entry a cycle, through all of its
// NumTypes*(MaxPower+1) entries (448 by default); no item is taken meanwhile. A load
// item is written in the cycle it is taken. An evaluate item's time is set mostly by the
// 64-step shared divider that runs twelve times (six normalizations, six gradients); the
// two 32-step square roots and the multiplier steps of the polynomial add the rest. A term
// with a zero-length bond goes from the length check to the output. One item is worked on
// at a time; the result waits in an output register while the next item is taken.
module cosine_angle_energy_gradient_top
  import caeg_pkg::*;
#(
  parameter int MaxPower = MAX_POWER_DEF,
  parameter int NumTypes = NUM_TYPES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  localparam int NPow  = MaxPower + 1;
  localparam int Depth = NumTypes * NPow;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = $clog2(MaxPower + 1);

  caeg_state_t state, state_next;

  // coefficient memory
  logic signed [31:0] coef_mem [Depth];
  logic [AW-1:0]      mem_waddr, mem_raddr, clr_addr;
  logic               mem_we;
  logic signed [31:0] mem_wdata, mem_rdata;

  // item and working registers
  logic signed [31:0] v [6];
  logic signed [31:0] u [6];
  logic signed [63:0] g [6];
  logic [5:0]         ty;
  logic               ty_ok;
  logic               last;
  logic               degen;
  logic [2:0]         idx;
  logic [PW-1:0]      p;
  logic [63:0]        sq_ij, sq_kj;
  logic [31:0]        r_ij, r_kj;
  logic signed [63:0] dot;
  logic signed [31:0] cosv, cn, co, c_reg;
  logic signed [39:0] e, df;
  logic               div_neg;
  logic signed [47:0] acc;

  // shared multiplier
  logic signed [39:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [72:0] prod;

  // shared divider and root
  logic              div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_num, div_q;
  logic [DIV_DW-1:0] div_den;
  logic              sqrt_start, sqrt_busy, sqrt_done;
  logic [SQRT_RW-1:0] sqrt_root;

  // helpers
  logic               in_acc, load_ok, out_load;
  logic [2:0]         oth;
  logic signed [31:0] u_own, u_oth;
  logic [31:0]        r_sel, v_abs, qc;
  logic signed [31:0] norm_u, cos_c;
  logic signed [63:0] dot_sh, grad_q;
  logic signed [33:0] g_diff;
  logic signed [19:0] d16;
  logic signed [47:0] num48;
  logic [47:0]        num_abs;
  logic signed [47:0] e_sum;
  out_item_t          out_next;

  assign in_acc  = in_valid && in_ready;
  assign load_ok = (32'(in_data.power_index) <= MaxPower) && (32'(in_data.term_type) < NumTypes);

  caeg_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num), .divisor(div_den),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  caeg_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(idx[0] ? sq_kj : sq_ij),
    .busy(sqrt_busy), .done(sqrt_done), .root(sqrt_root)
  );

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      coef_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= coef_mem[mem_raddr];
  end

  always_comb begin
    mem_we    = (state == ST_CLEAR) || (in_acc && in_data.mode == MODE_LOAD && load_ok);
    mem_waddr = (state == ST_CLEAR) ? clr_addr :
                AW'(32'(in_data.term_type) * NPow + 32'(in_data.power_index));
    mem_wdata = (state == ST_CLEAR) ? 32'sd0 : in_data.coefficient;
    mem_raddr = AW'(32'(ty) * NPow + 32'(p));
  end

  // datapath helpers
  always_comb begin
    oth    = (idx < 3'd3) ? idx + 3'd3 : idx - 3'd3;
    u_own  = u[idx];
    u_oth  = u[oth];
    r_sel  = (idx < 3'd3) ? r_ij : r_kj;
    v_abs  = v[idx][31] ? 32'(-v[idx]) : 32'(v[idx]);
    qc     = (div_q > 64'(ONE30)) ? 32'(ONE30) : div_q[31:0];
    norm_u = div_neg ? -signed'(qc) : signed'(qc);
    grad_q = div_neg ? -signed'(div_q) : signed'(div_q);
    dot_sh = dot >>> 30;
    cos_c  = (dot_sh > 64'(ONE30)) ? ONE30 :
             ((dot_sh < 64'(NEG_ONE30)) ? NEG_ONE30 : 32'(dot_sh));
    g_diff = 34'(u_oth) - 34'(prod >>> 30);
    d16    = 20'(g_diff >>> 14);
    num48  = 48'(prod >>> 16);
    num_abs = num48[47] ? 48'(-num48) : 48'(num48);
    e_sum  = sat48(64'(acc) + 64'(e));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:     if (clr_addr == AW'(Depth - 1)) state_next = ST_IDLE;
      ST_IDLE:      if (in_valid && in_data.mode == MODE_EVAL) state_next = ST_SQ_MUL;
      ST_SQ_MUL:    state_next = ST_SQ_ACC;
      ST_SQ_ACC:    state_next = (idx == 3'd5) ? ST_SQ_CHK : ST_SQ_MUL;
      ST_SQ_CHK:    state_next = (sq_ij == '0 || sq_kj == '0) ? ST_FIN : ST_SQRT_GO;
      ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sqrt_done) state_next = (idx == 3'd1) ? ST_NORM_GO : ST_SQRT_GO;
      ST_NORM_GO:   state_next = ST_NORM_WAIT;
      ST_NORM_WAIT: if (div_done) state_next = (idx == 3'd5) ? ST_DOT_MUL : ST_NORM_GO;
      ST_DOT_MUL:   state_next = ST_DOT_ACC;
      ST_DOT_ACC:   state_next = (idx == 3'd2) ? ST_COS : ST_DOT_MUL;
      ST_COS:       state_next = ST_P_RD;
      ST_P_RD:      state_next = ST_P_LAT;
      ST_P_LAT:     state_next = ST_P_M1;
      ST_P_M1:      state_next = ST_P_M2;
      ST_P_M2:      state_next = ST_P_M3;
      ST_P_M3:      state_next = ST_P_M4;
      ST_P_M4:      state_next = ST_P_M5;
      ST_P_M5:      state_next = (p == PW'(MaxPower)) ? ST_G_M1 : ST_P_RD;
      ST_G_M1:      state_next = ST_G_M2;
      ST_G_M2:      state_next = ST_G_DIV;
      ST_G_DIV:     state_next = ST_G_WAIT;
      ST_G_WAIT:    if (div_done) state_next = (idx == 3'd5) ? ST_FIN : ST_G_M1;
      ST_FIN:       if (!out_valid || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // control outputs and shared-unit operands
  always_comb begin
    in_ready   = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_num    = {2'b00, v_abs, 30'd0};
    div_den    = r_sel;
    case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_SQ_MUL: begin
        mul_a = 40'(v[idx]);
        mul_b = 33'(v[idx]);
      end
      ST_SQRT_GO: sqrt_start = 1'b1;
      ST_NORM_GO: div_start = 1'b1;
      ST_DOT_MUL: begin
        mul_a = 40'(u[idx]);
        mul_b = 33'(u[oth]);
      end
      ST_P_M1: begin
        mul_a = 40'(c_reg);
        mul_b = 33'(cn);
      end
      ST_P_M2: begin
        mul_a = 40'(c_reg);
        mul_b = 33'(co);
      end
      ST_P_M3: begin
        mul_a = 40'(prod >>> 30);
        mul_b = 33'(p);
      end
      ST_P_M4: begin
        mul_a = 40'(cn);
        mul_b = 33'(cosv);
      end
      ST_G_M1: begin
        mul_a = 40'(cosv);
        mul_b = 33'(u_own);
      end
      ST_G_M2: begin
        mul_a = df;
        mul_b = 33'(d16);
      end
      ST_G_DIV: begin
        div_start = 1'b1;
        div_num   = {num_abs, 16'd0};
      end
      ST_FIN:     out_load = !out_valid || out_ready;
      default:    in_ready = 1'b0;
    endcase
  end

  always_comb begin
    out_next = '0;
    out_next.degenerate = degen;
    if (degen) begin
      out_next.energy_sum = acc;
    end else begin
      out_next.term_energy   = 48'(e);
      out_next.energy_sum    = e_sum;
      out_next.grad_first_x  = sat48(g[0]);
      out_next.grad_first_y  = sat48(g[1]);
      out_next.grad_first_z  = sat48(g[2]);
      out_next.grad_third_x  = sat48(g[3]);
      out_next.grad_third_y  = sat48(g[4]);
      out_next.grad_third_z  = sat48(g[5]);
      out_next.grad_center_x = sat48(-(g[0] + g[3]));
      out_next.grad_center_y = sat48(-(g[1] + g[4]));
      out_next.grad_center_z = sat48(-(g[2] + g[5]));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
        acc       <= last ? 48'sd0 : (degen ? acc : e_sum);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid && in_data.mode == MODE_EVAL) begin
          v[0]  <= in_data.disp_ij_x;
          v[1]  <= in_data.disp_ij_y;
          v[2]  <= in_data.disp_ij_z;
          v[3]  <= in_data.disp_kj_x;
          v[4]  <= in_data.disp_kj_y;
          v[5]  <= in_data.disp_kj_z;
          ty    <= in_data.term_type;
          ty_ok <= 32'(in_data.term_type) < NumTypes;
          last  <= in_data.last_term;
          idx   <= '0;
          sq_ij <= '0;
          sq_kj <= '0;
        end
      end
      ST_SQ_ACC: begin
        if (idx < 3'd3) begin
          sq_ij <= sq_ij + prod[63:0];
        end else begin
          sq_kj <= sq_kj + prod[63:0];
        end
        idx <= (idx == 3'd5) ? 3'd0 : idx + 3'd1;
      end
      ST_SQ_CHK: begin
        degen <= (sq_ij == '0 || sq_kj == '0);
        idx   <= '0;
      end
      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          if (idx[0]) begin
            r_kj <= sqrt_root;
          end else begin
            r_ij <= sqrt_root;
          end
          idx <= (idx == 3'd1) ? 3'd0 : idx + 3'd1;
        end
      end
      ST_NORM_GO: div_neg <= v[idx][31];
      ST_NORM_WAIT: begin
        if (div_done) begin
          u[idx] <= norm_u;
          idx    <= (idx == 3'd5) ? 3'd0 : idx + 3'd1;
          dot    <= '0;
        end
      end
      ST_DOT_ACC: begin
        dot <= dot + 64'(prod);
        idx <= (idx == 3'd2) ? 3'd0 : idx + 3'd1;
      end
      ST_COS: begin
        cosv <= cos_c;
        p    <= '0;
        e    <= '0;
        df   <= '0;
        cn   <= ONE30;
        co   <= '0;
      end
      ST_P_LAT: c_reg <= ty_ok ? mem_rdata : 32'sd0;
      ST_P_M2:  e <= e + 40'(prod >>> 30);
      ST_P_M4:  df <= df + 40'(prod);
      ST_P_M5: begin
        co <= cn;
        cn <= 32'(prod >>> 30);
        if (p != PW'(MaxPower)) begin
          p <= p + 1'b1;
        end
      end
      ST_G_DIV: div_neg <= prod[72];
      ST_G_WAIT: begin
        if (div_done) begin
          g[idx] <= grad_q;
          idx    <= (idx == 3'd5) ? 3'd0 : idx + 3'd1;
        end
      end
      default: ;
    endcase
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("item taken during memory clear");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    sqrt_start |-> !sqrt_busy)
    else $error("square root started while busy");

  a_eval_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode == MODE_EVAL |=> !in_ready)
    else $error("new item taken while a term is in work");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.degenerate |->
      out_data.term_energy == '0 && out_data.grad_first_x == '0 &&
      out_data.grad_center_y == '0 && out_data.grad_third_z == '0)
    else $error("degenerate term with nonzero result");

endmodule

FILE: tb/sv/cosine_angle_energy_gradient_top_tb.sv
// Testbench for cosine_angle_energy_gradient_top: coefficient loads and angle terms
// are driven from a queue and results are checked against an in-bench fixed-point model.
// Depends on caeg_pkg and the block's RTL.
`timescale 1ns / 100ps

module cosine_angle_energy_gradient_top_tb;
  import caeg_pkg::*;

  localparam int NPow = MAX_POWER_DEF + 1;
  localparam int WatchLimit = 20000;
  localparam int InBits = $bits(in_item_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  cosine_angle_energy_gradient_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  logic signed [31:0] coef_mem[NUM_TYPES_DEF*NPow];
  logic signed [63:0] energy_acc;
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;

  function automatic logic signed [63:0] clamp64(logic signed [63:0] v,
      logic signed [63:0] lo, logic signed [63:0] hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] outer_grad(logic signed [63:0] df, cosv, a, b, r);
    logic signed [63:0] diff, d16, num;
    diff = b - ((cosv * a) >>> 30);
    d16 = diff >>> 14;
    num = (df * d16) >>> 16;
    return (num * 64'sd65536) / r;
  endfunction

  task automatic predict_term(input in_item_t it);
    logic signed [63:0] vi[3], vk[3], ui[3], uk[3], gi[3], gk[3];
    logic [63:0] sij, skj;
    logic signed [63:0] rij, rkj, cosv, e, df, cn, co, dot, c, one;
    out_item_t r;
    sij = 0; skj = 0; e = 0; df = 0; dot = 0; co = 0;
    one = 64'sd1 << 30;
    cn = one;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      if (it.power_index <= MAX_POWER_DEF)
        coef_mem[it.term_type*NPow + it.power_index] = it.coefficient;
      return;
    end
    vi[0] = it.disp_ij_x; vi[1] = it.disp_ij_y; vi[2] = it.disp_ij_z;
    vk[0] = it.disp_kj_x; vk[1] = it.disp_kj_y; vk[2] = it.disp_kj_z;
    for (int n = 0; n < 3; n++) begin
      sij += vi[n] * vi[n];
      skj += vk[n] * vk[n];
    end
    if (sij == 0 || skj == 0) begin
      r.energy_sum = sat48(energy_acc);
      r.degenerate = 1'b1;
    end else begin
      rij = root64(sij);
      rkj = root64(skj);
      for (int n = 0; n < 3; n++) begin
        ui[n] = clamp64((vi[n] * one) / rij, -one, one);
        uk[n] = clamp64((vk[n] * one) / rkj, -one, one);
        dot += ui[n] * uk[n];
      end
      cosv = clamp64(dot >>> 30, -one, one);
      for (int p = 0; p <= MAX_POWER_DEF; p++) begin
        c = coef_mem[it.term_type*NPow + p];
        df += p * ((c * co) >>> 30);
        e += (c * cn) >>> 30;
        co = cn;
        cn = (cn * cosv) >>> 30;
      end
      for (int n = 0; n < 3; n++) begin
        gi[n] = outer_grad(df, cosv, ui[n], uk[n], rij);
        gk[n] = outer_grad(df, cosv, uk[n], ui[n], rkj);
      end
      e = clamp64(e, SAT_LO, SAT_HI);
      energy_acc = clamp64(energy_acc + e, SAT_LO, SAT_HI);
      r.term_energy = sat48(e);
      r.energy_sum = sat48(energy_acc);
      r.grad_first_x = sat48(gi[0]); r.grad_first_y = sat48(gi[1]);
      r.grad_first_z = sat48(gi[2]);
      r.grad_center_x = sat48(-gi[0] - gk[0]); r.grad_center_y = sat48(-gi[1] - gk[1]);
      r.grad_center_z = sat48(-gi[2] - gk[2]);
      r.grad_third_x = sat48(gk[0]); r.grad_third_y = sat48(gk[1]);
      r.grad_third_z = sat48(gk[2]);
    end
    expected_results.push_back(r);
    if (it.last_term) energy_acc = 0;
  endtask

  function automatic logic [31:0] rand_disp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8)) - 4);
      2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
    endcase
  endfunction

  function automatic in_item_t load_item(int ty, int pw, logic [31:0] c);
    in_item_t it;
    it = in_item_t'(InBits'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom(), $urandom()}));
    it.mode = MODE_LOAD;
    it.term_type = 6'(ty);
    it.power_index = 3'(pw);
    it.coefficient = c;
    return it;
  endfunction

  function automatic in_item_t eval_item(int ty, bit lst);
    in_item_t it;
    it = load_item(ty, $urandom_range(0, 7), $urandom());
    it.mode = MODE_EVAL;
    it.disp_ij_x = rand_disp(); it.disp_ij_y = rand_disp(); it.disp_ij_z = rand_disp();
    it.disp_kj_x = rand_disp(); it.disp_kj_y = rand_disp(); it.disp_kj_z = rand_disp();
    if ($urandom_range(0, 15) == 0) {it.disp_ij_x, it.disp_ij_y, it.disp_ij_z} = '0;
    if ($urandom_range(0, 15) == 0) {it.disp_kj_x, it.disp_kj_y, it.disp_kj_z} = '0;
    it.last_term = lst;
    return it;
  endfunction

  initial begin
    in_item_t it;
    for (int i = 0; i < NUM_TYPES_DEF*NPow; i++) coef_mem[i] = '0;
    energy_acc = 0;
    // directed: zero table, loads at extremes, out-of-range power, degenerate bonds
    it = eval_item(0, 0);
    it.disp_ij_x = 32'h0001_0000; it.disp_ij_y = 0; it.disp_ij_z = 0;
    it.disp_kj_x = 0; it.disp_kj_y = 32'h0001_0000; it.disp_kj_z = 0;
    pending_items.push_back(it);
    for (int p = 0; p < 8; p++)
      pending_items.push_back(load_item(1, p, p[0] ? 32'h7FFF_FFFF : 32'h8000_0000));
    for (int p = 0; p <= MAX_POWER_DEF; p++)
      pending_items.push_back(load_item(63, p, 32'h0001_0000 * (p + 1)));
    it = eval_item(1, 0);
    it.disp_ij_x = 32'h7FFF_FFFF; it.disp_ij_y = 32'h8000_0000; it.disp_ij_z = 32'h7FFF_FFFF;
    it.disp_kj_x = 32'h8000_0000; it.disp_kj_y = 32'h7FFF_FFFF; it.disp_kj_z = 32'h8000_0000;
    pending_items.push_back(it);
    it = eval_item(63, 0);
    it.disp_ij_x = 32'h0002_0000; it.disp_kj_x = 32'h0003_0000;
    it.disp_ij_y = 0; it.disp_ij_z = 0; it.disp_kj_y = 0; it.disp_kj_z = 0;
    pending_items.push_back(it);
    it.disp_kj_x = 32'hFFFD_0000;
    pending_items.push_back(it);
    it = eval_item(63, 1);
    {it.disp_ij_x, it.disp_ij_y, it.disp_ij_z} = '0;
    pending_items.push_back(it);
    it = eval_item(1, 1);
    {it.disp_kj_x, it.disp_kj_y, it.disp_kj_z} = '0;
    pending_items.push_back(it);
    // random: loads and terms mixed, about one load in four items
    while (pending_items.size() < 1900) begin
      if ($urandom_range(0, 3) == 0) begin
        it = load_item($urandom_range(0, 63), $urandom_range(0, 7), $urandom());
        if ($urandom_range(0, 2) == 0) it.coefficient = {{14{it.coefficient[31]}}, it.coefficient[17:0]};
        pending_items.push_back(it);
      end else begin
        pending_items.push_back(eval_item($urandom_range(0, 1) ? $urandom_range(0, 3)
                                          : $urandom_range(0, 63), $urandom_range(0, 4) == 0));
      end
    end
    stim_done = 1'b1;
  end

  int in_wait = 0;
  int out_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_term(in_data);
        in_wait = $urandom_range(0, 5);
      end
      if (!in_valid || in_ready) begin
        if (in_wait > 0 || pending_items.size() == 0) begin
          if (in_wait > 0) in_wait--;
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_data);
          errors++;
        end else if (expected_results[0] !== out_data) begin
          $display("%0t mismatch expected %h actual %h", $time, expected_results[0], out_data);
          errors++;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
        out_wait = $urandom_range(0, 5);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (stim_done);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(posedge clk);
      if (idle_cycles > WatchLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    repeat (1000) @(posedge clk);
    if (errors == 0 && !out_valid) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
